>>> src/bsm_pkg.sv
// ----------------------------------------------------------------------------
// bsm_pkg
// Shared types and constants for the bank-switch mapper with scanline IRQ.
// ----------------------------------------------------------------------------
`default_nettype none

package bsm_pkg;

    // Field widths
    localparam int CMD_W        = 2;
    localparam int ADDR_W       = 16;
    localparam int DATA_W       = 8;
    localparam int MAP_W        = 21;
    localparam int BANK_W       = 8;
    localparam int PRG_CNT_W    = 9;
    localparam int CHR_SIZE_W   = 19;
    localparam int CFG_DATA_W   = 19;
    localparam int CFG_IDX_W    = 2;
    localparam int NUM_BANK_REGS = 8;
    localparam int BANK_IDX_W   = 3;
    localparam int PRG_OFS_W    = 13;

    // Untranslated pattern address width and remainder unit sizing
    localparam int PAT_W        = 18;
    localparam int DIV_STEPS    = PAT_W;
    localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

    // CPU register decode boundaries
    localparam logic [ADDR_W-1:0] BOUND_SELECT = 16'h9FFF;
    localparam logic [ADDR_W-1:0] BOUND_MIRROR = 16'hBFFF;
    localparam logic [ADDR_W-1:0] BOUND_LATCH  = 16'hDFFF;

    // Pattern window boundaries
    localparam logic [ADDR_W-1:0] PAT_0400 = 16'h0400;
    localparam logic [ADDR_W-1:0] PAT_0800 = 16'h0800;
    localparam logic [ADDR_W-1:0] PAT_0C00 = 16'h0C00;
    localparam logic [ADDR_W-1:0] PAT_1000 = 16'h1000;
    localparam logic [ADDR_W-1:0] PAT_1400 = 16'h1400;
    localparam logic [ADDR_W-1:0] PAT_1800 = 16'h1800;
    localparam logic [ADDR_W-1:0] PAT_1C00 = 16'h1C00;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_REG_WRITE = 2'd0,
        CMD_PRG_XLATE = 2'd1,
        CMD_CHR_XLATE = 2'd2,
        CMD_SCANLINE  = 2'd3
    } bsm_cmd_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRG_BANK_COUNT  = 2'd0,
        CFG_CHR_SIZE_BYTES  = 2'd1,
        CFG_CHR_IS_RAM      = 2'd2,
        CFG_MIRROR_AT_RESET = 2'd3
    } bsm_cfg_idx_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_FINISH
    } bsm_state_t;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] data;
    } bsm_in_t;

    typedef struct packed {
        logic [MAP_W-1:0] mapped_address;
        logic             irq_request;
        logic             mirroring;
        logic             no_program_banks;
    } bsm_out_t;

    // Controller to datapath
    typedef struct packed {
        logic load_in;
        logic exec;
        logic div_step;
        logic load_out;
    } bsm_cmd_bus_t;

    // Datapath to controller
    typedef struct packed {
        logic div_needed;
    } bsm_status_t;

endpackage

`default_nettype wire

>>> src/bsm_ctrl.sv
// ----------------------------------------------------------------------------
// bsm_ctrl
// Sequencer: accepts a word, runs execute and, when needed, the remainder
// steps, and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bsm_ctrl
    import bsm_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  wire logic         out_ready,
    output bsm_cmd_bus_t      cmd,
    input  wire bsm_status_t  status
);

    bsm_state_t             state_reg, state_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                   out_valid_reg, out_valid_next;

    // State, step counter and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                if (status.div_needed)
                begin
                    cnt_next   = DIV_CNT_W'(DIV_STEPS - 1);
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0)
                    state_next = ST_FINISH;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            ST_FINISH:
            begin
                // Wait for the output register to free up
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the result word until taken
    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

>>> src/bsm_datapath.sv
// ----------------------------------------------------------------------------
// bsm_datapath
// Mapper registers, address translation, scanline counter and a
// bit-serial remainder unit for the pattern size modulus.
// ----------------------------------------------------------------------------
`default_nettype none

module bsm_datapath
    import bsm_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire bsm_in_t                in_word,
    output bsm_out_t                    out_word,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire bsm_cmd_bus_t           cmd,
    output bsm_status_t                 status
);

    // Configuration
    logic [PRG_CNT_W-1:0]   prg_banks_reg;
    logic [CHR_SIZE_W-1:0]  chr_size_reg;
    logic                   chr_ram_reg;

    // Mapper state
    logic [BANK_W-1:0]      bank_select_reg, bank_select_next;
    logic [BANK_W-1:0]      bank_regs_reg [NUM_BANK_REGS];
    logic                   bank_we;
    logic [BANK_W-1:0]      bank_wdata;
    logic                   mirror_reg, mirror_next;
    logic [BANK_W-1:0]      latch_reg, latch_next;
    logic [BANK_W-1:0]      count_reg, count_next;
    logic                   reload_reg, reload_next;
    logic                   enabled_reg, enabled_next;
    logic                   pending_reg, pending_next;

    // Item and result
    bsm_in_t                item_reg;
    logic [MAP_W-1:0]       result_reg, result_next;
    logic                   no_banks_reg, no_banks_next;
    logic                   use_rem_reg, use_rem_next;
    logic [PAT_W-1:0]       dividend_reg;
    logic [CHR_SIZE_W-1:0]  rem_reg;
    bsm_out_t               out_word_reg;

    // Combinational helpers
    bsm_cmd_t               item_cmd;
    logic [ADDR_W-1:0]      a;
    logic                   odd;
    logic [BANK_W-1:0]      prg_mask, prg_second, prg_bank;
    logic [PAT_W-1:0]       pat_addr;
    logic [CHR_SIZE_W:0]    trial, trial_sub;
    logic [CHR_SIZE_W-1:0]  rem_next_val;

    assign item_cmd = bsm_cmd_t'(item_reg.command);
    assign a        = item_reg.address;
    assign odd      = a[0];

    assign status.div_needed = (item_cmd == CMD_CHR_XLATE) && !chr_ram_reg
                               && (chr_size_reg != '0);

    // Program window translation
    always_comb
    begin
        prg_mask   = BANK_W'(prg_banks_reg - PRG_CNT_W'(1));
        prg_second = BANK_W'(prg_banks_reg - PRG_CNT_W'(2));
        if (a <= BOUND_SELECT)
            prg_bank = bank_select_reg[6] ? prg_second : (bank_regs_reg[6] & prg_mask);
        else if (a <= BOUND_MIRROR)
            prg_bank = bank_regs_reg[7] & prg_mask;
        else if (a <= BOUND_LATCH)
            prg_bank = bank_select_reg[6] ? (bank_regs_reg[6] & prg_mask) : prg_second;
        else
            prg_bank = prg_mask;
    end

    // Pattern window translation, before the size modulus
    always_comb
    begin
        if (!bank_select_reg[7])
        begin
            if (a < PAT_0800)
                pat_addr = {bank_regs_reg[0][7:1], a[10:0]};
            else if (a < PAT_1000)
                pat_addr = {bank_regs_reg[1][7:1], a[10:0]};
            else if (a < PAT_1400)
                pat_addr = {bank_regs_reg[2], a[9:0]};
            else if (a < PAT_1800)
                pat_addr = {bank_regs_reg[3], a[9:0]};
            else if (a < PAT_1C00)
                pat_addr = {bank_regs_reg[4], a[9:0]};
            else
                pat_addr = {bank_regs_reg[5], a[9:0]};
        end
        else
        begin
            if (a < PAT_0400)
                pat_addr = {bank_regs_reg[2], a[9:0]};
            else if (a < PAT_0800)
                pat_addr = {bank_regs_reg[3], a[9:0]};
            else if (a < PAT_0C00)
                pat_addr = {bank_regs_reg[4], a[9:0]};
            else if (a < PAT_1000)
                pat_addr = {bank_regs_reg[5], a[9:0]};
            else if (a < PAT_1800)
                pat_addr = {bank_regs_reg[0][7:1], a[10:0]};
            else
                pat_addr = {bank_regs_reg[1][7:1], a[10:0]};
        end
    end

    // Execute: register writes, scanline tick and direct results
    always_comb
    begin
        bank_select_next = bank_select_reg;
        bank_we          = 1'b0;
        bank_wdata       = item_reg.data;
        mirror_next      = mirror_reg;
        latch_next       = latch_reg;
        count_next       = count_reg;
        reload_next      = reload_reg;
        enabled_next     = enabled_reg;
        pending_next     = pending_reg;
        result_next      = '0;
        no_banks_next    = 1'b0;
        use_rem_next     = 1'b0;
        case (item_cmd)
            CMD_REG_WRITE:
            begin
                if (a <= BOUND_SELECT)
                begin
                    if (!odd)
                        bank_select_next = item_reg.data;
                    else
                        bank_we = 1'b1;
                end
                else if (a <= BOUND_MIRROR)
                begin
                    if (!odd)
                        mirror_next = ~item_reg.data[0];
                end
                else if (a <= BOUND_LATCH)
                begin
                    if (!odd)
                    begin
                        latch_next = item_reg.data;
                    end
                    else
                    begin
                        count_next  = '0;
                        reload_next = 1'b1;
                    end
                end
                else
                begin
                    if (!odd)
                    begin
                        pending_next = 1'b0;
                        enabled_next = 1'b0;
                    end
                    else
                    begin
                        enabled_next = 1'b1;
                    end
                end
            end
            CMD_PRG_XLATE:
            begin
                if (prg_banks_reg == '0)
                    no_banks_next = 1'b1;
                else
                    result_next = {prg_bank, a[PRG_OFS_W-1:0]};
            end
            CMD_CHR_XLATE:
            begin
                if (chr_ram_reg)
                    result_next = MAP_W'(a[PRG_OFS_W-1:0]);
                else
                    use_rem_next = (chr_size_reg != '0);
            end
            CMD_SCANLINE:
            begin
                // Reload on flag or zero, else count down and flag at zero if enabled
                if (reload_reg || (count_reg == '0))
                begin
                    count_next  = latch_reg;
                    reload_next = 1'b0;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    if ((count_reg == BANK_W'(1)) && enabled_reg)
                        pending_next = 1'b1;
                end
            end
            default:
            begin
                result_next = '0;
            end
        endcase
    end

    // One restoring remainder step
    always_comb
    begin
        trial     = {rem_reg, dividend_reg[PAT_W-1]};
        trial_sub = trial - {1'b0, chr_size_reg};
        if (trial >= {1'b0, chr_size_reg})
            rem_next_val = trial_sub[CHR_SIZE_W-1:0];
        else
            rem_next_val = trial[CHR_SIZE_W-1:0];
    end

    // Configuration and control-state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_banks_reg   <= PRG_CNT_W'(32);
            chr_size_reg    <= CHR_SIZE_W'(131072);
            chr_ram_reg     <= 1'b0;
            bank_select_reg <= '0;
            mirror_reg      <= 1'b0;
            latch_reg       <= '0;
            count_reg       <= '0;
            reload_reg      <= 1'b0;
            enabled_reg     <= 1'b0;
            pending_reg     <= 1'b0;
            for (int i = 0; i < NUM_BANK_REGS; i++)
                bank_regs_reg[i] <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (bsm_cfg_idx_t'(cfg_index))
                    CFG_PRG_BANK_COUNT:  prg_banks_reg <= cfg_data[PRG_CNT_W-1:0];
                    CFG_CHR_SIZE_BYTES:  chr_size_reg  <= cfg_data[CHR_SIZE_W-1:0];
                    CFG_CHR_IS_RAM:      chr_ram_reg   <= cfg_data[0];
                    CFG_MIRROR_AT_RESET: mirror_reg    <= cfg_data[0];
                    default:             chr_ram_reg   <= chr_ram_reg;
                endcase
            end
            else if (cmd.exec)
            begin
                bank_select_reg <= bank_select_next;
                mirror_reg      <= mirror_next;
                latch_reg       <= latch_next;
                count_reg       <= count_next;
                reload_reg      <= reload_next;
                enabled_reg     <= enabled_next;
                pending_reg     <= pending_next;
                if (bank_we)
                    bank_regs_reg[bank_select_reg[BANK_IDX_W-1:0]] <= bank_wdata;
            end
        end
    end

    // Payload: item, result, remainder and output word
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
            item_reg <= in_word;
        if (cmd.exec)
        begin
            result_reg   <= result_next;
            no_banks_reg <= no_banks_next;
            use_rem_reg  <= use_rem_next;
            dividend_reg <= pat_addr;
            rem_reg      <= '0;
        end
        else if (cmd.div_step)
        begin
            dividend_reg <= {dividend_reg[PAT_W-2:0], 1'b0};
            rem_reg      <= rem_next_val;
        end
        if (cmd.load_out)
        begin
            out_word_reg.mapped_address   <= use_rem_reg ? MAP_W'(rem_reg) : result_reg;
            out_word_reg.irq_request      <= pending_reg;
            out_word_reg.mirroring        <= mirror_reg;
            out_word_reg.no_program_banks <= no_banks_reg;
        end
    end

    assign out_word = out_word_reg;

endmodule

`default_nettype wire

>>> src/bank_switch_mapper_scanline_irq_unit.sv
// ----------------------------------------------------------------------------
// bank_switch_mapper_scanline_irq_unit
// Cartridge bank-switch mapper with a scanline interrupt counter.
// ----------------------------------------------------------------------------
//  Channel   Signals                          Dir  Word
//  in        in_valid / in_ready / in_word    in   command, address, data
//  out       out_valid / out_ready / out_word out  mapped_address, irq, mirroring,
//                                                  no_program_banks
//  cfg       cfg_we / cfg_index / cfg_data    in   config register write
//
//  One word at a time. Register writes, program translations, scanline
//  ticks and pattern RAM pass from execute straight to the output
//  register; pattern ROM translation with a nonzero size runs the 18
//  one-bit steps of the remainder unit in between. A stalled result sits
//  in the output register while the next word is accepted; the sequencer
//  waits only to hand over its result.
//  Reset is asynchronous, active low; config registers return to defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module bank_switch_mapper_scanline_irq_unit
    import bsm_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire bsm_in_t                in_word,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output bsm_out_t                    out_word,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    bsm_cmd_bus_t cmd;
    bsm_status_t  status;

    // Sequencer
    bsm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    // Registers, translation and remainder unit
    bsm_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_word   (in_word),
        .out_word  (out_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire
